// ----- sv/radix_node48_child_table_unit_defines.svh -----
// assertion macros for the node48 child table unit
`ifndef RADIX_NODE48_CHILD_TABLE_UNIT_DEFINES_SVH
`define RADIX_NODE48_CHILD_TABLE_UNIT_DEFINES_SVH

// checked only outside reset
`define RN48_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define RN48_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/rn48_pkg.sv -----
// shared constants and types of the node48 child table unit
`default_nettype none

package rn48_pkg;

   localparam int SLOT_COUNT_DEF = 48;
   localparam int CHILD_BITS_DEF = 64;
   localparam int KEY_SPACE      = 256;
   localparam int KEY_W          = 8;
   localparam int REF_W          = 64;
   localparam int CNT_W          = 6;
   localparam int REQ_W          = 2;
   localparam int STATUS_W       = 3;
   localparam int REQ_DATA_W     = 72;
   localparam int RSP_DATA_W     = 80;

   typedef enum logic [REQ_W-1:0] {
      REQ_FIND   = 2'd0,
      REQ_ADD    = 2'd1,
      REQ_REMOVE = 2'd2
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 3'd0,
      ST_NULL   = 3'd1,
      ST_FULL   = 3'd2,
      ST_EMPTY  = 3'd3,
      ST_EXISTS = 3'd4,
      ST_ABSENT = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_IDX  = 3'b010,
      S_DAT  = 3'b100
   } state_type;

endpackage

`default_nettype wire

// ----- sv/radix_node48_child_table_unit.sv -----
// node48 child table: key byte index memory, child slot memory and request sequencer
`default_nettype none
`include "radix_node48_child_table_unit_defines.svh"

// Node48 child table of a radix tree node. A request transfer carries the operation in
// req_tuser (find, add, remove) and the key byte and child reference in req_tdata; each
// request yields exactly one response transfer with status, found flag, child reference
// and the slot count after the request. One request is in work at a time. The response
// register is loaded from the S_IDX state for add, remove and the unused operation code
// and from the S_DAT state, entered after S_IDX, for find; the next request is taken the
// cycle after the response is loaded, even while that response still waits on rsp_tready.
// A response still held by rsp_tready stalls the following request at its load step.
// This sequence comes from the registered read of the key index memory followed, for find
// only, by the read of the child slot memory. Both memories start out empty through
// per-entry valid bits, so there is no clearing pass after reset; add picks the lowest
// free slot from a slot occupancy map.
module radix_node48_child_table_unit
   import rn48_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF,
   parameter int CHILD_BITS = CHILD_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // key[7:0], child_ref[71:8]
   input  wire logic [REQ_W-1:0]      req_tuser,  // req_type[1:0]
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata   // status[2:0], found[3],
                                                  // child_out[67:4], child_count[73:68]
);

   localparam int SLOT_W = $clog2(SLOT_COUNT);

   // request registers
   state_type             state_ff, state_in;
   logic [REQ_W-1:0]      req_kind_ff;
   logic [KEY_W-1:0]      key_ff;
   logic [CHILD_BITS-1:0] child_ff;
   logic                  key_hit_ff;

   // memories and their read registers
   logic [SLOT_W-1:0]     key_mem [KEY_SPACE];
   logic [CHILD_BITS-1:0] child_mem [SLOT_COUNT];
   logic [SLOT_W-1:0]     idx_rd_ff;
   logic [CHILD_BITS-1:0] child_rd_ff;

   // valid bits and occupancy
   logic [KEY_SPACE-1:0]  key_valid_ff;
   logic [SLOT_COUNT-1:0] slot_used_ff;
   logic [CNT_W-1:0]      count_ff, count_in;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic                  req_fire;
   logic                  out_free;
   logic                  load_rsp;
   logic                  add_wr;
   logic                  rem_wr;
   logic [SLOT_W-1:0]     lowest_free;
   logic                  free_found;
   status_type            rsp_status;
   logic                  rsp_found;
   logic [REF_W-1:0]      rsp_child;
   logic                  node_full;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign node_full  = (count_ff >= CNT_W'(SLOT_COUNT));
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // lowest free slot
   always_comb begin
      lowest_free = '0;
      free_found  = 1'b0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!slot_used_ff[i]) begin
            free_found  = 1'b1;
            lowest_free = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      load_rsp     = 1'b0;
      add_wr       = 1'b0;
      rem_wr       = 1'b0;
      rsp_status   = ST_OK;
      rsp_found    = 1'b0;
      rsp_child    = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_IDX;
         end
         S_IDX: begin
            if (req_kind_ff == REQ_FIND) begin
               state_in = S_DAT;
            end else if (out_free) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
               case (req_kind_ff)
                  REQ_ADD: begin
                     if (child_ff == '0) begin
                        rsp_status = ST_NULL;
                     end else if (node_full) begin
                        rsp_status = ST_FULL;
                     end else if (key_hit_ff) begin
                        rsp_status = ST_EXISTS;
                     end else if (!free_found) begin
                        rsp_status = ST_FULL;
                     end else begin
                        add_wr   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  REQ_REMOVE: begin
                     if (count_ff == '0) begin
                        rsp_status = ST_EMPTY;
                     end else if (!key_hit_ff) begin
                        rsp_status = ST_ABSENT;
                     end else begin
                        rem_wr   = 1'b1;
                        count_in = count_ff - 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_DAT: begin
            if (out_free) begin
               load_rsp  = 1'b1;
               state_in  = S_IDLE;
               rsp_found = key_hit_ff;
               rsp_child = key_hit_ff ? REF_W'(child_rd_ff) : '0;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (load_rsp) rsp_valid_in = 1'b1;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         key_valid_ff <= '0;
         slot_used_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         if (add_wr) begin
            key_valid_ff[key_ff]      <= 1'b1;
            slot_used_ff[lowest_free] <= 1'b1;
         end
         if (rem_wr) begin
            key_valid_ff[key_ff]    <= 1'b0;
            slot_used_ff[idx_rd_ff] <= 1'b0;
         end
      end
   end

   // request and response payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_kind_ff <= req_tuser;
         key_ff      <= req_tdata[KEY_W-1:0];
         child_ff    <= req_tdata[KEY_W +: CHILD_BITS];
         key_hit_ff  <= key_valid_ff[req_tdata[KEY_W-1:0]];
      end
      if (load_rsp) begin
         rsp_data_ff <= {(RSP_DATA_W - STATUS_W - 1 - REF_W - CNT_W)'(0),
                         count_in, rsp_child, rsp_found, rsp_status};
      end
   end

   // key index memory
   always_ff @(posedge clock) begin
      if (add_wr) key_mem[key_ff] <= lowest_free;
      if (req_fire) idx_rd_ff <= key_mem[req_tdata[KEY_W-1:0]];
   end

   // child slot memory
   always_ff @(posedge clock) begin
      if (add_wr) child_mem[lowest_free] <= child_ff;
      if (state_ff == S_IDX) child_rd_ff <= child_mem[idx_rd_ff];
   end

   `RN48_ASSERT(a_count_matches_map, clock, reset,
      ($countones(slot_used_ff) == 32'(count_ff)), "slot count differs from occupancy map")
   `RN48_ASSERT(a_add_counts_up, clock, reset,
      add_wr |=> (count_ff == CNT_W'($past(count_ff) + 1'b1)), "add did not raise the count")
   `RN48_ASSERT(a_rsp_after_work, clock, reset,
      $rose(rsp_valid_ff) |-> ($past(state_ff) != S_IDLE), "response without a request")
   `RN48_ASSERT_ALWAYS(a_reset_clears_rsp, clock,
      reset |=> !rsp_valid_ff, "response valid after reset")

endmodule

`default_nettype wire
